// File: rtl/core/rotate_by_angle_controller_defines.svh
// Assertion macros for the rotate-by-angle controller.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef ROTATE_BY_ANGLE_CONTROLLER_DEFINES_SVH
`define ROTATE_BY_ANGLE_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked at every rising clock edge, reset included.
`define RBA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
// Checked only while the active-low reset is released.
`define RBA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define RBA_ASSERT_ALWAYS(label, clk, prop, msg)
`define RBA_ASSERT(label, clk, rst_n, prop, msg)
`endif
`endif

// File: rtl/core/rba_pkg.sv
// Shared types and constants of the rotate-by-angle controller.
// No dependencies; used by every other RTL file of the block.
package rba_pkg;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdYaw     = 2'd1,
    CmdTurn    = 2'd2,
    CmdReverse = 2'd3
  } rba_cmd_e;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 15;
  localparam int unsigned RateW     = 15;
  localparam int unsigned TolW      = 14;
  localparam int unsigned AngW      = 16;

  localparam logic [CfgIdxW-1:0] CfgTurnRate     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReverseSpeed = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWrapTol      = 2'd2;

  localparam logic [RateW-1:0] TurnRateRst     = 15'd2048;
  localparam logic [RateW-1:0] ReverseSpeedRst = 15'd410;
  localparam logic [TolW-1:0]  WrapTolRst      = 14'd410;

  // Two pi and pi in Q3.12 radians.
  localparam logic signed [AngW-1:0] TwoPiQ = 16'sd25736;
  localparam logic signed [AngW-1:0] PiQ    = 16'sd12868;
  // Turn amount meaning no turn pending.
  localparam logic signed [AngW-1:0] NoTurn = -16'sd1;

  typedef struct packed {
    logic [RateW-1:0] turn_rate;
    logic [RateW-1:0] reverse_speed;
    logic [TolW-1:0]  wrap_tolerance;
  } rba_cfg_t;

  typedef struct packed {
    logic signed [AngW-1:0] current_yaw;
    logic signed [AngW-1:0] start_yaw;
    logic                   turn_dir;
    logic signed [AngW-1:0] turn_amount;
    logic                   reverse_mode;
    logic                   turning_flag;
  } rba_state_t;

  typedef struct packed {
    rba_cmd_e               cmd;
    logic signed [AngW-1:0] value;
    logic                   flag;
  } rba_item_t;

  typedef struct packed {
    logic                   valid;
    logic signed [AngW-1:0] angular_rate;
    logic signed [AngW-1:0] linear_rate;
    logic                   turning;
  } rba_result_t;

endpackage

// File: rtl/core/rba_in_if.sv
// Input channel of the rotate-by-angle controller: valid/ready plus command payload.
// Depends on rba_pkg for the field widths.
interface rba_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic signed [rba_pkg::AngW-1:0] value;
  logic                           flag;

  modport source (output valid, output cmd, output value, output flag, input ready);
  modport sink   (input valid, input cmd, input value, input flag, output ready);
endinterface

// File: rtl/core/rba_out_if.sv
// Output channel of the rotate-by-angle controller: valid/ready plus rate commands.
// Depends on rba_pkg for the field widths.
interface rba_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [rba_pkg::AngW-1:0] angular_rate;
  logic signed [rba_pkg::AngW-1:0] linear_rate;
  logic                            turning;

  modport source (output valid, output angular_rate, output linear_rate, output turning,
                  input ready);
  modport sink   (input valid, input angular_rate, input linear_rate, input turning,
                  output ready);
endinterface

// File: rtl/core/rotate_by_angle_controller.sv
// Rotate-by-angle controller: top level with input register, state and result register.
// Depends on rba_pkg, rba_in_if, rba_out_if, rba_cfg_regs, rba_step and the defines header.
//
// Usage: commands arrive as beats on in_beat (cmd, value, flag). A yaw sample
// (cmd 1) updates the current heading, a turn request (cmd 2) starts a turn,
// a reverse flag (cmd 3) sets reverse mode, and a tick (cmd 0) produces one
// beat on out_beat with the angular and linear rate to command and the
// turning status after that tick. Other commands produce no output beat.
// Configuration registers (turn rate, reverse speed, wrap tolerance) are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while the block is idle, since the block itself does not enforce it.
// A tick accepted into the input register is evaluated once the result
// register can take a beat; its result is then captured in the result
// register and is valid on out_beat. Throughput is one command per cycle
// while the receiver does not stall, limited only by the single input
// register and single result register. When the receiver stalls, the result
// register holds its beat and the input register keeps one more command;
// after that in_beat.ready drops.
// Reset clears all turn state (no turn pending, clockwise, yaws zero), loads
// the configuration defaults and empties both registers.
`include "rotate_by_angle_controller_defines.svh"
module rotate_by_angle_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rba_in_if.sink                       in_beat,
  rba_out_if.source                    out_beat,
  input  logic                         cfg_we_i,
  input  logic [rba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rba_pkg::CfgDataW-1:0] cfg_data_i
);

  rba_pkg::rba_cfg_t    cfg;
  rba_pkg::rba_state_t  state_q, state_d;
  rba_pkg::rba_item_t   item_q;
  rba_pkg::rba_result_t result;
  logic item_valid_q;
  logic out_valid_q;
  logic signed [rba_pkg::AngW-1:0] ang_q, lin_q;
  logic turning_q;
  logic process;
  logic in_take;

  rba_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rba_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // The registered command is evaluated once the result register can take a beat.
  assign process       = item_valid_q && (!out_valid_q || out_beat.ready);
  assign in_beat.ready = !item_valid_q || process;
  assign in_take       = in_beat.valid && in_beat.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_beat.ready) begin
      item_valid_q <= in_beat.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd   <= rba_pkg::rba_cmd_e'(in_beat.cmd);
      item_q.value <= in_beat.value;
      item_q.flag  <= in_beat.flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.current_yaw  <= '0;
      state_q.start_yaw    <= '0;
      state_q.turn_dir     <= 1'b0;
      state_q.turn_amount  <= rba_pkg::NoTurn;
      state_q.reverse_mode <= 1'b0;
      state_q.turning_flag <= 1'b0;
    end else if (process) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && result.valid) begin
      ang_q     <= result.angular_rate;
      lin_q     <= result.linear_rate;
      turning_q <= result.turning;
    end
  end

  assign out_beat.valid        = out_valid_q;
  assign out_beat.angular_rate = ang_q;
  assign out_beat.linear_rate  = lin_q;
  assign out_beat.turning      = turning_q;

  // A pending turn never exceeds pi and no-turn is only ever zero or minus one.
  `RBA_ASSERT(a_amount_range, clk_i, rst_ni,
              (state_q.turn_amount <= rba_pkg::PiQ && state_q.turn_amount >= rba_pkg::NoTurn),
              "turn amount out of range")
  // A command waiting for the result register stays in the input register.
  `RBA_ASSERT(a_item_held, clk_i, rst_ni,
              (item_valid_q && !process |=> item_valid_q && $stable(item_q)),
              "stalled command lost")
  // A reported turn in progress never comes with a reverse speed.
  `RBA_ASSERT(a_turn_no_reverse, clk_i, rst_ni, (out_valid_q && turning_q |-> lin_q == '0),
              "turning while reversing")
  // The turning flag is only set while a turn is pending.
  `RBA_ASSERT(a_flag_pending, clk_i, rst_ni,
              (state_q.turning_flag |-> state_q.turn_amount > 16'sd0),
              "turning flag without pending turn")

endmodule

// File: rtl/core/rba_cfg_regs.sv
// Configuration register file of the rotate-by-angle controller.
// Depends on rba_pkg.
module rba_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rba_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rba_pkg::CfgDataW-1:0]  cfg_data_i,
  output rba_pkg::rba_cfg_t             cfg_o
);

  rba_pkg::rba_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_rate      <= rba_pkg::TurnRateRst;
      cfg_q.reverse_speed  <= rba_pkg::ReverseSpeedRst;
      cfg_q.wrap_tolerance <= rba_pkg::WrapTolRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rba_pkg::CfgTurnRate:     cfg_q.turn_rate      <= cfg_data_i;
        rba_pkg::CfgReverseSpeed: cfg_q.reverse_speed  <= cfg_data_i;
        rba_pkg::CfgWrapTol:      cfg_q.wrap_tolerance <= cfg_data_i[rba_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/rba_step.sv
// Next-state and result logic for one command of the rotate-by-angle controller.
// Purely combinational; depends on rba_pkg.
module rba_step (
  input  rba_pkg::rba_cfg_t    cfg_i,
  input  rba_pkg::rba_state_t  state_i,
  input  rba_pkg::rba_item_t   item_i,
  output rba_pkg::rba_state_t  state_o,
  output rba_pkg::rba_result_t result_o
);

  localparam int unsigned WideW = 19;

  logic signed [WideW-1:0] cur_w, start_w, tol_w, two_pi_w, diff_w, turned_w, amount_w;
  logic signed [WideW-1:0] val_w;
  logic signed [rba_pkg::AngW-1:0] rate_s;
  logic done;

  // Angle turned since the start yaw, allowing for wraparound past +/-pi.
  always_comb begin
    cur_w    = WideW'(state_i.current_yaw);
    start_w  = WideW'(state_i.start_yaw);
    tol_w    = $signed({{(WideW-rba_pkg::TolW){1'b0}}, cfg_i.wrap_tolerance});
    two_pi_w = WideW'(rba_pkg::TwoPiQ);
    amount_w = WideW'(state_i.turn_amount);
    diff_w   = start_w - cur_w;
    if (state_i.turn_dir) begin
      turned_w = (diff_w <= tol_w) ? (cur_w - start_w) : (two_pi_w - start_w + cur_w);
    end else begin
      turned_w = (diff_w >= -tol_w) ? diff_w : (two_pi_w - cur_w + start_w);
    end
    done = turned_w > amount_w;
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    val_w    = WideW'(item_i.value);
    rate_s   = $signed({1'b0, cfg_i.turn_rate});
    case (item_i.cmd)
      rba_pkg::CmdYaw: begin
        state_o.current_yaw = item_i.value;
      end
      rba_pkg::CmdReverse: begin
        state_o.reverse_mode = item_i.flag;
      end
      rba_pkg::CmdTurn: begin
        // Requests while busy or beyond a full circle are dropped; zero does nothing.
        if (!(val_w > WideW'(rba_pkg::TwoPiQ) || val_w < -WideW'(rba_pkg::TwoPiQ)
              || state_i.turn_amount > 16'sd0)) begin
          if (item_i.value > rba_pkg::PiQ) begin
            state_o.turn_dir    = 1'b0;
            state_o.turn_amount = rba_pkg::TwoPiQ - item_i.value;
          end else if (item_i.value > 16'sd0) begin
            state_o.turn_dir    = 1'b1;
            state_o.turn_amount = item_i.value;
          end else if (item_i.value < 16'sd0 && item_i.value >= -rba_pkg::PiQ) begin
            state_o.turn_dir    = 1'b0;
            state_o.turn_amount = -item_i.value;
          end else if (item_i.value < -rba_pkg::PiQ) begin
            state_o.turn_dir    = 1'b1;
            state_o.turn_amount = rba_pkg::TwoPiQ + item_i.value;
          end
        end
      end
      rba_pkg::CmdTick: begin
        result_o.valid = 1'b1;
        if (state_i.turn_amount > 16'sd0) begin
          state_o.turning_flag  = 1'b1;
          result_o.angular_rate = state_i.turn_dir ? rate_s : -rate_s;
          if (done) begin
            state_o.start_yaw    = state_i.current_yaw;
            state_o.turn_amount  = rba_pkg::NoTurn;
            state_o.turning_flag = 1'b0;
          end
        end else if (state_i.reverse_mode) begin
          result_o.linear_rate = -$signed({1'b0, cfg_i.reverse_speed});
        end else begin
          state_o.turning_flag = 1'b0;
          state_o.start_yaw    = state_i.current_yaw;
        end
        result_o.turning = state_o.turning_flag;
      end
      default: ;
    endcase
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the rotate-by-angle controller.
// Needs rba_pkg, the rba_in_if and rba_out_if channels and the controller itself.
// Commands go in as beats, and every tick's rate beat is checked against a local predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rba_pkg::*;

  // Angle constants widened to int so that yaw differences never overflow.
  localparam int TwoPiI = int'(TwoPiQ);
  localparam int PiI    = int'(PiQ);
  localparam int NoTurnI = int'(NoTurn);

  // Cycles to let the pipeline empty before a register write or the end of the run.
  localparam int unsigned SettleCycles = 8;
  // Cycles without any accepted beat, on either side, after which the run is declared hung.
  localparam int unsigned HangLimit = 4000;

  typedef struct packed {
    logic signed [AngW-1:0] angular_rate;
    logic signed [AngW-1:0] linear_rate;
    logic                   turning;
  } rate_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rba_in_if  cmd_ch ();
  rba_out_if rate_ch ();

  rotate_by_angle_controller dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_beat   (cmd_ch),
    .out_beat  (rate_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Commands waiting to be driven, and the rate beats that accepted ticks must produce.
  rba_item_t  cmd_backlog[$];
  rate_beat_t rate_beats_due[$];
  rba_item_t  head_cmd;
  rate_beat_t want_beat;

  // When set, neither side inserts gaps, so the block runs at full throughput.
  bit steady_flow = 1'b0;

  int unsigned queued_total;
  int unsigned cmds_accepted;
  int unsigned beats_checked;
  int unsigned turns_finished;
  int unsigned reverse_ticks;
  int unsigned phases_run;
  int unsigned faults;
  int unsigned quiet_cycles;

  // Predictor copy of the configuration; it starts at the reset values.
  int turn_rate_q  = int'(TurnRateRst);
  int rev_speed_q  = int'(ReverseSpeedRst);
  int wrap_tol_q   = int'(WrapTolRst);

  // Predictor copy of the turn state, in the reset condition.
  int heading      = 0;
  int origin_yaw   = 0;
  bit ccw          = 1'b0;
  int pending_turn = NoTurnI;
  bit backing_up   = 1'b0;
  bit turn_active  = 1'b0;

  // Applies one accepted command to the predicted state. Only a tick yields a rate beat.
  function automatic void predict_rates(rba_cmd_e cmd, logic signed [AngW-1:0] value,
                                        logic flag);
    int         v;
    int         ang;
    int         lin;
    int         turned;
    rate_beat_t beat;
    v   = int'(value);
    ang = 0;
    lin = 0;
    case (cmd)
      CmdYaw: begin
        heading = v;
      end
      CmdReverse: begin
        backing_up = flag;
      end
      CmdTurn: begin
        // A request only lands when no turn is pending and it lies within one full circle.
        // It is folded into a direction and an amount no larger than half a circle.
        if (v <= TwoPiI && v >= -TwoPiI && pending_turn <= 0) begin
          if (v > PiI) begin
            ccw = 1'b0;
            pending_turn = TwoPiI - v;
          end else if (v > 0) begin
            ccw = 1'b1;
            pending_turn = v;
          end else if (v < 0 && v >= -PiI) begin
            ccw = 1'b0;
            pending_turn = -v;
          end else if (v < -PiI) begin
            ccw = 1'b1;
            pending_turn = TwoPiI + v;
          end
        end
      end
      default: begin
        if (pending_turn > 0) begin
          turn_active = 1'b1;
          ang = ccw ? turn_rate_q : -turn_rate_q;
          // The angle turned so far; a yaw step against the turn beyond the tolerance
          // means the heading wrapped past the half-circle boundary.
          if (ccw) begin
            if (origin_yaw - heading <= wrap_tol_q) turned = heading - origin_yaw;
            else turned = TwoPiI - origin_yaw + heading;
          end else begin
            if (origin_yaw - heading >= -wrap_tol_q) turned = origin_yaw - heading;
            else turned = TwoPiI - heading + origin_yaw;
          end
          if (turned > pending_turn) begin
            origin_yaw   = heading;
            pending_turn = NoTurnI;
            turn_active  = 1'b0;
            turns_finished++;
          end
        end else if (backing_up) begin
          // Reversing leaves the start yaw and the turning flag alone.
          lin = -rev_speed_q;
          reverse_ticks++;
        end else begin
          turn_active = 1'b0;
          origin_yaw  = heading;
        end
        beat.angular_rate = ang[AngW-1:0];
        beat.linear_rate  = lin[AngW-1:0];
        beat.turning      = turn_active;
        rate_beats_due.push_back(beat);
      end
    endcase
  endfunction

  function automatic void queue_cmd(rba_cmd_e cmd, logic signed [AngW-1:0] value, logic flag);
    rba_item_t it;
    it.cmd   = cmd;
    it.value = value;
    it.flag  = flag;
    cmd_backlog.push_back(it);
    queued_total++;
  endfunction

  // Random traffic. Most of it is turn sequences: a yaw sample, an idle tick that
  // latches the start yaw, a turn request, and then yaw samples moving the way the
  // turn goes, each followed by a tick. Stray commands, busy requests and reverse
  // stretches are mixed in.
  function automatic void queue_random_traffic(int unsigned quota);
    int unsigned first;
    int          yaw;
    int          angle;
    int          dir;
    int          step;
    int unsigned steps;
    int unsigned pick;
    first = queued_total;
    while (queued_total - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        // A stray command with every field random.
        queue_cmd(rba_cmd_e'($urandom_range(3)), AngW'($urandom), 1'($urandom));
      end else if (pick < 24) begin
        // A reverse stretch; it only shows on the ticks if no turn is pending.
        queue_cmd(CmdReverse, AngW'($urandom), 1'b1);
        steps = $urandom_range(1, 4);
        for (int unsigned i = 0; i < steps; i++) begin
          queue_cmd(CmdTick, AngW'($urandom), 1'($urandom));
        end
        queue_cmd(CmdReverse, AngW'($urandom), ($urandom_range(99) < 80) ? 1'b0 : 1'b1);
      end else begin
        yaw = int'($urandom_range(2 * PiI)) - PiI;
        queue_cmd(CmdYaw, AngW'(yaw), 1'($urandom));
        queue_cmd(CmdTick, AngW'($urandom), 1'($urandom));
        pick = $urandom_range(99);
        if (pick < 10) angle = int'($signed(AngW'($urandom)));
        else if (pick < 16) begin
          case ($urandom_range(4))
            0: angle = TwoPiI;
            1: angle = -TwoPiI;
            2: angle = PiI;
            3: angle = -PiI;
            default: angle = 0;
          endcase
        end else angle = int'($urandom_range(2 * TwoPiI)) - TwoPiI;
        queue_cmd(CmdTurn, AngW'(angle), 1'($urandom));
        dir = ((angle > 0 && angle <= PiI) || angle < -PiI) ? 1 : -1;
        steps = $urandom_range(1, 35);
        for (int unsigned i = 0; i < steps; i++) begin
          step = int'($urandom_range(1200));
          if ($urandom_range(99) < 10) step = -int'($urandom_range(300));
          yaw = yaw + dir * step;
          if (yaw > PiI) yaw = yaw - TwoPiI;
          if (yaw < -PiI) yaw = yaw + TwoPiI;
          queue_cmd(CmdYaw, AngW'(yaw), 1'($urandom));
          queue_cmd(CmdTick, AngW'($urandom), 1'($urandom));
          if ($urandom_range(99) < 8) begin
            // A request while the turn is still under way should be dropped.
            queue_cmd(CmdTurn, AngW'(int'($urandom_range(2 * TwoPiI)) - TwoPiI), 1'b0);
          end
        end
      end
    end
  endfunction

  // Waits for every queued beat to be accepted and every expected rate beat to
  // arrive, then lets the pipeline run dry.
  task automatic drain_then_settle();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || rate_beats_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the block is idle, so the predictor takes the value at once.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(data);
    case (idx)
      CfgTurnRate:     turn_rate_q = int'(data & 32'h7fff);
      CfgReverseSpeed: rev_speed_q = int'(data & 32'h7fff);
      CfgWrapTol:      wrap_tol_q  = int'(data & 32'h3fff);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_settings(int unsigned rate, int unsigned rev, int unsigned tol);
    write_reg(CfgTurnRate, rate);
    write_reg(CfgReverseSpeed, rev);
    write_reg(CfgWrapTol, tol);
  endtask

  // Command driver: presents the next queued beat once the previous one is taken,
  // and leaves random gaps unless the steady phase is running.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (cmd_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 27)) begin
        head_cmd = cmd_backlog.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd   <= head_cmd.cmd;
        cmd_ch.value <= head_cmd.value;
        cmd_ch.flag  <= head_cmd.flag;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random in the same proportion.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rate_ch.ready <= 1'b0;
    end else begin
      rate_ch.ready <= steady_flow || ($urandom_range(99) >= 27);
    end
  end

  // Every command beat that the block takes is fed to the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && cmd_ch.valid && cmd_ch.ready) begin
      predict_rates(rba_cmd_e'(cmd_ch.cmd), cmd_ch.value, cmd_ch.flag);
      cmds_accepted++;
    end
  end

  // Every rate beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rate_ch.valid && rate_ch.ready) begin
      if (rate_beats_due.size() == 0) begin
        $error("unexpected rate beat: angular_rate %0d linear_rate %0d turning %0b",
               rate_ch.angular_rate, rate_ch.linear_rate, rate_ch.turning);
        faults++;
      end else begin
        want_beat = rate_beats_due.pop_front();
        if (rate_ch.angular_rate !== want_beat.angular_rate) begin
          $error("angular_rate: expected %0d, got %0d", want_beat.angular_rate,
                 rate_ch.angular_rate);
          faults++;
        end
        if (rate_ch.linear_rate !== want_beat.linear_rate) begin
          $error("linear_rate: expected %0d, got %0d", want_beat.linear_rate,
                 rate_ch.linear_rate);
          faults++;
        end
        if (rate_ch.turning !== want_beat.turning) begin
          $error("turning: expected %0b, got %0b", want_beat.turning, rate_ch.turning);
          faults++;
        end
        beats_checked++;
      end
    end
  end

  // Hang detection: the run stops if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (rate_ch.valid && rate_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("hang: no beat accepted for %0d cycles, %0d rate beats outstanding",
               HangLimit, rate_beats_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Every input is known from time zero.
    rst_ni        = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.cmd    = CmdTick;
    cmd_ch.value  = '0;
    cmd_ch.flag   = 1'b0;
    rate_ch.ready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgTurnRate;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset settings. An idle tick right out of reset.
    queue_cmd(CmdTick, '0, 1'b0);
    // Yaw samples at both ends of the field.
    queue_cmd(CmdYaw, 16'sh7fff, 1'b1);
    queue_cmd(CmdYaw, 16'sh8000, 1'b0);
    queue_cmd(CmdYaw, '0, 1'b0);
    // Requests beyond a full circle and a zero request are all ignored.
    queue_cmd(CmdTurn, AngW'(TwoPiI + 1), 1'b0);
    queue_cmd(CmdTurn, 16'sh8000, 1'b0);
    queue_cmd(CmdTurn, '0, 1'b0);
    // A full circle either way folds to nothing pending, so the ticks stay idle.
    queue_cmd(CmdTurn, AngW'(TwoPiI), 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    queue_cmd(CmdTurn, AngW'(-TwoPiI), 1'b0);
    // Reversing while idle, then back to standing still.
    queue_cmd(CmdReverse, '0, 1'b1);
    queue_cmd(CmdTick, '0, 1'b0);
    queue_cmd(CmdReverse, 16'shffff, 1'b0);
    // A small counterclockwise turn; the second request arrives while busy.
    queue_cmd(CmdTurn, 16'sd1000, 1'b0);
    queue_cmd(CmdTurn, -16'sd500, 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    queue_cmd(CmdYaw, 16'sd1500, 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    // More than half a circle folds into a clockwise turn.
    queue_cmd(CmdTurn, 16'sd20000, 1'b0);
    queue_cmd(CmdYaw, -16'sd5000, 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    // Counterclockwise turn across the half-circle boundary, so the yaw wraps.
    queue_cmd(CmdYaw, 16'sd12000, 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    queue_cmd(CmdTurn, -16'sd20000, 1'b0);
    queue_cmd(CmdYaw, -16'sd11000, 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    queue_cmd(CmdYaw, -16'sd6000, 1'b0);
    queue_cmd(CmdTick, '0, 1'b0);
    queue_random_traffic(150);
    drain_then_settle();
    phases_run++;

    // Largest rates and a tolerance of half a circle, with no gaps on either side.
    steady_flow = 1'b1;
    load_settings(32767, 32767, PiI);
    queue_random_traffic(180);
    drain_then_settle();
    steady_flow = 1'b0;
    phases_run++;

    // Everything at zero: the turn rate vanishes and any backward step means a wrap.
    load_settings(0, 0, 0);
    queue_random_traffic(180);
    drain_then_settle();
    phases_run++;

    // Random settings: rates across their full ranges, tolerance up to half a circle.
    load_settings($urandom_range(32767), $urandom_range(32767), $urandom_range(PiI));
    queue_random_traffic(180);
    drain_then_settle();
    phases_run++;

    if (rate_beats_due.size() != 0) begin
      $error("%0d rate beats never arrived", rate_beats_due.size());
      faults++;
    end
    $display("covered %0d command beats over %0d setting phases, %0d rate beats checked",
             cmds_accepted, phases_run, beats_checked);
    $display("%0d turns ran to completion and %0d ticks were spent reversing",
             turns_finished, reverse_ticks);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
